// ----- src/amtn_pkg.sv -----
// Shared constants, codes and types of the accelerometer median/trim/normalize filter.
package amtn_pkg;

    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int SAMPLES_PER_MEDIAN = 3;
    localparam int MEDIANS_PER_RESULT = 4;
    localparam int AXES               = 3;
    localparam int FRAC_BITS          = 8;
    localparam int OUT_BITS           = FRAC_BITS + 1;
    localparam int CFG_IDX_BITS       = 3;

    localparam int PHASE_BITS = $clog2(SAMPLES_PER_MEDIAN);
    localparam int SLOT_BITS  = $clog2(MEDIANS_PER_RESULT);
    localparam int AXIS_BITS  = $clog2(AXES);

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(SAMPLES_PER_MEDIAN - 1);
    localparam logic [SLOT_BITS-1:0]  SLOT_LAST  = SLOT_BITS'(MEDIANS_PER_RESULT - 1);
    localparam logic [AXIS_BITS-1:0]  AXIS_LAST  = AXIS_BITS'(AXES - 1);

    localparam logic signed [OUT_BITS-1:0] NORM_MAX  = OUT_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [OUT_BITS-1:0] NORM_MIN  = -NORM_MAX;
    localparam logic signed [OUT_BITS-1:0] NORM_ZERO = '0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MED  = 5'b00010,
        S_TRIM = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                       done;
        logic signed [OUT_BITS-1:0] value;
    } norm_rsp_t;

endpackage

// ----- src/amtn_sample_if.sv -----
// Input channel: one three-axis raw sample per item.
interface amtn_sample_if import amtn_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

// ----- src/amtn_result_if.sv -----
// Output channel: one three-axis normalized result per item.
interface amtn_result_if import amtn_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] norm_x;
    logic signed [OUT_BITS-1:0] norm_y;
    logic signed [OUT_BITS-1:0] norm_z;

    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    input ready);
    modport sink   (input valid, input norm_x, input norm_y, input norm_z,
                    output ready);
endinterface

// ----- src/accel_median_trim_normalize_top.sv -----
// Accelerometer median-of-three, trimmed-mean and normalize filter: top level.
//
// Items arrive on the samples channel (valid/ready), one raw x/y/z sample each.
// Every three items give a median of three per axis; every four medians (twelve
// items) are trimmed to the mean of the middle two per axis and mapped to
// (avg-low)*256/(high-low)-128, saturated to -128..128, with 0 for an axis whose
// high calibration is not above its low one. One item leaves on the results
// channel for every twelve taken.
// Timing: the first two items of a triple are only registered. The third then runs
// through the shared median unit (one axis a cycle). The twelfth then runs the
// shared normalizer once per axis, by the 8-step restoring divider unless the axis
// saturates or is degenerate, and the result is registered. Ready is low while the
// sequencer is busy. The result sits in an output register; the next item is taken
// while it waits. A stalled receiver blocks only when the next result is ready to
// be loaded. Calibration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while the block is idle, the block does not enforce this.
// Reset restores low 0 and high full scale per axis and starts a new round.
module accel_median_trim_normalize_top import amtn_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    amtn_sample_if.sink             samples,
    amtn_result_if.source           results,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]  cfg_data
);

    function automatic logic [SAMPLE_BITS-1:0] med3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    state_t                  state_reg, state_next;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic [AXIS_BITS-1:0]    axis_reg, axis_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]  low_cal_reg  [AXES];
    logic [SAMPLE_BITS-1:0]  high_cal_reg [AXES];
    logic [SAMPLE_BITS-1:0]  raw_a_reg    [AXES];
    logic [SAMPLE_BITS-1:0]  raw_b_reg    [AXES];
    logic [SAMPLE_BITS-1:0]  samp_reg     [AXES];
    logic [SAMPLE_BITS-1:0]  med_reg      [MEDIANS_PER_RESULT][AXES];
    logic signed [OUT_BITS-1:0] res_reg   [AXES];
    logic signed [OUT_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;

    logic [SAMPLE_BITS-1:0]  in_vec [AXES];
    logic                    accept;
    logic                    norm_start;
    logic                    load_out;
    logic [SAMPLE_BITS-1:0]  med;
    logic [SAMPLE_BITS-1:0]  lo1, hi1, lo2, hi2, mid_lo, mid_hi;
    logic [SAMPLE_BITS:0]    mid_sum;
    logic [SAMPLE_BITS-1:0]  avg;
    norm_rsp_t               norm_rsp;

    assign in_vec[0] = samples.sample_x;
    assign in_vec[1] = samples.sample_y;
    assign in_vec[2] = samples.sample_z;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    assign med = med3(raw_a_reg[axis_reg], raw_b_reg[axis_reg], samp_reg[axis_reg]);

    // Middle two of four: larger of the pair minima plus smaller of the pair maxima
    assign lo1     = (med_reg[0][axis_reg] < med_reg[1][axis_reg]) ? med_reg[0][axis_reg]
                                                                   : med_reg[1][axis_reg];
    assign hi1     = (med_reg[0][axis_reg] < med_reg[1][axis_reg]) ? med_reg[1][axis_reg]
                                                                   : med_reg[0][axis_reg];
    assign lo2     = (med_reg[2][axis_reg] < med_reg[3][axis_reg]) ? med_reg[2][axis_reg]
                                                                   : med_reg[3][axis_reg];
    assign hi2     = (med_reg[2][axis_reg] < med_reg[3][axis_reg]) ? med_reg[3][axis_reg]
                                                                   : med_reg[2][axis_reg];
    assign mid_lo  = (lo1 > lo2) ? lo1 : lo2;
    assign mid_hi  = (hi1 < hi2) ? hi1 : hi2;
    assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
    assign avg     = mid_sum[SAMPLE_BITS:1];

    amtn_norm #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .avg   (avg),
        .lo    (low_cal_reg[axis_reg]),
        .hi    (high_cal_reg[axis_reg]),
        .rsp   (norm_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        axis_next  = axis_reg;
        norm_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg == PHASE_LAST)
                    begin
                        state_next = S_MED;
                        axis_next  = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            S_MED:
            begin
                if (axis_reg == AXIS_LAST)
                begin
                    phase_next = '0;
                    axis_next  = '0;
                    if (slot_reg == SLOT_LAST)
                    begin
                        slot_next  = '0;
                        state_next = S_TRIM;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            S_TRIM:
            begin
                norm_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (norm_rsp.done)
                begin
                    if (axis_reg == AXIS_LAST)
                    begin
                        axis_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_TRIM;
                    end
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            slot_reg      <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                low_cal_reg[a]  <= '0;
                high_cal_reg[a] <= '1;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_X_LOW:  low_cal_reg[0]  <= cfg_data;
                    REG_X_HIGH: high_cal_reg[0] <= cfg_data;
                    REG_Y_LOW:  low_cal_reg[1]  <= cfg_data;
                    REG_Y_HIGH: high_cal_reg[1] <= cfg_data;
                    REG_Z_LOW:  low_cal_reg[2]  <= cfg_data;
                    REG_Z_HIGH: high_cal_reg[2] <= cfg_data;
                    default:    low_cal_reg[0]  <= low_cal_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                samp_reg[a] <= in_vec[a];
                if (phase_reg == '0)
                begin
                    raw_a_reg[a] <= in_vec[a];
                end
                if (phase_reg == PHASE_BITS'(1))
                begin
                    raw_b_reg[a] <= in_vec[a];
                end
            end
        end
        if (state_reg == S_MED)
        begin
            med_reg[slot_reg][axis_reg] <= med;
        end
        if (state_reg == S_DIV && norm_rsp.done)
        begin
            res_reg[axis_reg] <= norm_rsp.value;
        end
        if (load_out)
        begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.norm_x = out_x_reg;
    assign results.norm_y = out_y_reg;
    assign results.norm_z = out_z_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_no_early_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg != PHASE_LAST |=> state_reg == S_IDLE)
        else $error("sequencer left idle on an item that closes no triple");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("triple phase out of range");

    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output state");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        norm_rsp.done |-> state_reg == S_DIV)
        else $error("normalizer finished while not awaited");

endmodule

// ----- src/amtn_norm.sv -----
// Iterative normalizer: (avg-lo)*256/(hi-lo)-128 by restoring division, saturated.
module amtn_norm import amtn_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] avg,
    input  logic [SAMPLE_BITS-1:0] lo,
    input  logic [SAMPLE_BITS-1:0] hi,
    output norm_rsp_t              rsp
);

    localparam int CNT_BITS = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        N_IDLE = 3'b001,
        N_PREP = 3'b010,
        N_RUN  = 3'b100
    } nstate_t;

    nstate_t                    nstate_reg, nstate_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [SAMPLE_BITS-1:0]     avg_reg, lo_reg, hi_reg;
    logic [SAMPLE_BITS-1:0]     rem_reg, den_reg;
    logic [FRAC_BITS-1:0]       quo_reg;
    logic signed [OUT_BITS-1:0] value_reg;

    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;
    logic                   degenerate;
    logic                   below;
    logic                   over;
    logic [SAMPLE_BITS:0]   shifted;
    logic                   fits;
    logic [FRAC_BITS-1:0]   quo_final;

    assign diff       = avg_reg - lo_reg;
    assign span       = hi_reg - lo_reg;
    assign degenerate = (hi_reg <= lo_reg);
    assign below      = (avg_reg < lo_reg);
    assign over       = (diff >= span);
    assign shifted    = {rem_reg, 1'b0};
    assign fits       = (shifted >= {1'b0, den_reg});
    assign quo_final  = {quo_reg[FRAC_BITS-2:0], fits};

    always_comb
    begin
        nstate_next = nstate_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        unique case (nstate_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    nstate_next = N_PREP;
                end
            end
            N_PREP:
            begin
                if (degenerate || below || over)
                begin
                    nstate_next = N_IDLE;
                    done_next   = 1'b1;
                end
                else
                begin
                    nstate_next = N_RUN;
                    cnt_next    = CNT_BITS'(FRAC_BITS - 1);
                end
            end
            N_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    nstate_next = N_IDLE;
                    done_next   = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                nstate_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nstate_reg <= N_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            nstate_reg <= nstate_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (nstate_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    avg_reg <= avg;
                    lo_reg  <= lo;
                    hi_reg  <= hi;
                end
            end
            N_PREP:
            begin
                // Quotient of 256 or more saturates; below low calibration is negative unless degenerate
                priority if (degenerate)
                begin
                    value_reg <= NORM_ZERO;
                end
                else if (below)
                begin
                    value_reg <= NORM_MIN;
                end
                else if (over)
                begin
                    value_reg <= NORM_MAX;
                end
                else
                begin
                    rem_reg <= diff;
                    den_reg <= span;
                end
            end
            N_RUN:
            begin
                rem_reg <= fits ? SAMPLE_BITS'(shifted - {1'b0, den_reg})
                                : shifted[SAMPLE_BITS-1:0];
                quo_reg <= quo_final;
                if (cnt_reg == '0)
                begin
                    value_reg <= OUT_BITS'({1'b0, quo_final}) - NORM_MAX;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule
